// ----- design/audio_chunk_container_deframer_unit_assert.svh -----
// Assertion macros shared by the deframer modules.
`ifndef AUDIO_CHUNK_CONTAINER_DEFRAMER_UNIT_ASSERT_SVH
`define AUDIO_CHUNK_CONTAINER_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ACDF_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACDF_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- design/acdf_pkg.sv -----
// Shared types and constants for the audio chunk container deframer.
`timescale 1ns / 1ps
package acdf_pkg;

  localparam int FRAME_COUNT_WIDTH_DEFAULT = 40;
  localparam int CMD_QUEUE_DEPTH = 4;

  localparam int STAMP_W  = 44;
  localparam int MS_W     = 38;
  localparam int OFFSET_W = 32;
  localparam int RATE_W   = 16;
  localparam int SIZE_W   = 16;
  localparam int IDX_W    = 4;
  localparam int SCALE_W  = 17;

  localparam logic [SCALE_W-1:0] STAMP_SCALE = 17'd90000;
  localparam logic [6:0]         MS_DIVISOR  = 7'd90;

  // stamp / 90 in 11-bit digits, each digit quotient by reciprocal multiply
  localparam int MS_DIGIT_W     = 11;
  localparam int MS_REM_W       = 7;
  localparam int MS_PART_W      = MS_REM_W + MS_DIGIT_W;
  localparam int MS_RECIP_W     = 19;
  localparam int MS_PROD_W      = MS_PART_W + MS_RECIP_W;
  localparam int MS_RECIP_SHIFT = 25;
  localparam int MS_STEPS       = STAMP_W / MS_DIGIT_W;
  // ceil(2^25 / 90), exact for every partial remainder below 90 * 2^11
  localparam logic [MS_RECIP_W-1:0] MS_RECIP = 19'd372828;

  localparam logic [RATE_W-1:0] RATE_MIN = 16'd8000;
  localparam logic [RATE_W-1:0] RATE_MAX = 16'd48000;
  localparam logic [31:0]       CHUNK_MAGIC = 32'h0000_DEAF;
  localparam logic [7:0]        CODEC_BYTE_PLAIN = 8'd1;
  localparam logic [7:0]        CODEC_BYTE_IMA   = 8'd99;
  localparam logic [SIZE_W-1:0] MAX_BUFFER_RESET = 16'd8192;

  localparam int FLAG_STEREO_BIT = 0;
  localparam int FLAG_WIDE_BIT   = 1;

  localparam int HEADER_BYTES   = 12;
  localparam int PREAMBLE_BYTES = 8;

  // Byte positions inside the header and the chunk preamble
  localparam logic [IDX_W-1:0] HDR_RATE_LO = 4'd0;
  localparam logic [IDX_W-1:0] HDR_RATE_HI = 4'd1;
  localparam logic [IDX_W-1:0] HDR_FLAGS   = 4'd10;
  localparam logic [IDX_W-1:0] HDR_CODEC   = IDX_W'(HEADER_BYTES - 1);
  localparam logic [IDX_W-1:0] PRE_SIZE_LO = 4'd0;
  localparam logic [IDX_W-1:0] PRE_SIZE_HI = 4'd1;
  localparam logic [IDX_W-1:0] PRE_MAGIC_0 = 4'd4;
  localparam logic [IDX_W-1:0] PRE_MAGIC_1 = 4'd5;
  localparam logic [IDX_W-1:0] PRE_MAGIC_2 = 4'd6;
  localparam logic [IDX_W-1:0] PRE_MAGIC_3 = IDX_W'(PREAMBLE_BYTES - 1);

  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;

  localparam logic [2:0] REASON_EOS       = 3'd1;
  localparam logic [2:0] REASON_BAD_RATE  = 3'd2;
  localparam logic [2:0] REASON_BAD_CODEC = 3'd3;
  localparam logic [2:0] REASON_BAD_MAGIC = 3'd4;
  localparam logic [2:0] REASON_TRUNCATED = 3'd5;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PREAMBLE,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_BYTE,
    CMD_CHUNK,
    CMD_FINISH
  } cmd_op_t;

  typedef enum logic [1:0] {
    BK_SERVE,
    BK_MUL,
    BK_DIV,
    BK_MS
  } back_state_t;

  // One classified request from the front end
  typedef struct packed {
    cmd_op_t              op;
    logic [7:0]           data;
    logic                 buf_last;
    logic                 frm_last;
    logic [OFFSET_W-1:0]  offset;
    logic [RATE_W-1:0]    rate;
    logic                 stereo;
    logic                 sixteen;
    logic                 codec;
    logic [2:0]           reason;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           payload_byte;
    logic [RATE_W-1:0]    sample_rate;
    logic                 is_stereo;
    logic                 is_sixteen_bit;
    logic                 codec_kind;
    logic                 buffer_last;
    logic                 frame_last;
    logic [STAMP_W-1:0]   presentation_stamp;
    logic [MS_W-1:0]      time_ms;
    logic [OFFSET_W-1:0]  chunk_offset;
    logic [2:0]           finish_reason;
  } result_t;

endpackage

// ----- design/acdf_cmd_queue.sv -----
// Short request queue between the parsing front end and the back end.
`timescale 1ns / 1ps
`include "audio_chunk_container_deframer_unit_assert.svh"
module acdf_cmd_queue #(
  parameter int FRAME_COUNT_WIDTH = acdf_pkg::FRAME_COUNT_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  acdf_pkg::cmd_t               cmd_in,
  input  logic [FRAME_COUNT_WIDTH-1:0] frame_in,
  input  logic                         pop,
  output logic                         full,
  output logic                         empty,
  output acdf_pkg::cmd_t               head,
  output logic [FRAME_COUNT_WIDTH-1:0] head_frame
);

  localparam int DEPTH = acdf_pkg::CMD_QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  acdf_pkg::cmd_t               cmd_mem   [DEPTH];
  logic [FRAME_COUNT_WIDTH-1:0] frame_mem [DEPTH];
  logic [PTR_W-1:0]             wr_ptr;
  logic [PTR_W-1:0]             rd_ptr;
  logic [CNT_W-1:0]             count;

  assign full       = (count == CNT_W'(DEPTH));
  assign empty      = (count == '0);
  assign head       = cmd_mem[rd_ptr];
  assign head_frame = frame_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr]   <= cmd_in;
      frame_mem[wr_ptr] <= frame_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ACDF_ASSERT_NEXT(a_q_push_grows, clk, rst, push && !pop, count == $past(count) + CNT_W'(1), "queue push lost")
  `ACDF_ASSERT_NOW(a_q_pop_nonempty, clk, rst, pop, !empty, "pop from empty request queue")

endmodule

// ----- design/acdf_front.sv -----
// Front end: parses header and chunk preambles and classifies each byte.
`timescale 1ns / 1ps
`include "audio_chunk_container_deframer_unit_assert.svh"
module acdf_front #(
  parameter int FRAME_COUNT_WIDTH = acdf_pkg::FRAME_COUNT_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [7:0]                   data_byte_in,
  input  logic                         end_of_stream,
  input  logic                         cfg_write,
  input  logic [acdf_pkg::SIZE_W-1:0]  cfg_data,
  output logic                         cmd_push,
  output acdf_pkg::cmd_t               cmd,
  output logic [FRAME_COUNT_WIDTH-1:0] cmd_frame
);

  acdf_pkg::phase_t                  phase, phase_next;
  logic [acdf_pkg::IDX_W-1:0]        byte_idx, byte_idx_next;
  logic [acdf_pkg::RATE_W-1:0]       header_rate, header_rate_next;
  logic [1:0]                        header_flags, header_flags_next;
  logic                              codec, codec_next;
  logic [acdf_pkg::SIZE_W-1:0]       preamble_size, preamble_size_next;
  logic [31:0]                       preamble_magic, preamble_magic_next;
  logic [acdf_pkg::SIZE_W-1:0]       chunk_left, chunk_left_next;
  logic [acdf_pkg::SIZE_W-1:0]       buffer_fill, buffer_fill_next;
  logic [FRAME_COUNT_WIDTH-1:0]      frame_total, frame_total_next;
  logic [acdf_pkg::OFFSET_W-1:0]     data_position, data_position_next;
  logic [acdf_pkg::OFFSET_W-1:0]     chunk_offset, chunk_offset_next;
  logic [acdf_pkg::SIZE_W-1:0]       max_buffer_bytes, max_buffer_bytes_next;

  logic [acdf_pkg::SIZE_W-1:0]       limit;
  logic [31:0]                       magic_full;
  logic [FRAME_COUNT_WIDTH-1:0]      frame_add;
  logic [acdf_pkg::SIZE_W-1:0]       left_dec;
  logic [acdf_pkg::SIZE_W-1:0]       fill_inc;
  logic                              pay_frame_last;
  logic                              pay_buf_last;

  function automatic acdf_pkg::cmd_t finish_cmd(input logic [2:0] reason);
    acdf_pkg::cmd_t c;
    c        = '0;
    c.op     = acdf_pkg::CMD_FINISH;
    c.reason = reason;
    return c;
  endfunction

  assign cmd_frame = frame_total_next;

  always_comb begin
    phase_next            = phase;
    byte_idx_next         = byte_idx;
    header_rate_next      = header_rate;
    header_flags_next     = header_flags;
    codec_next            = codec;
    preamble_size_next    = preamble_size;
    preamble_magic_next   = preamble_magic;
    chunk_left_next       = chunk_left;
    buffer_fill_next      = buffer_fill;
    frame_total_next      = frame_total;
    data_position_next    = data_position;
    chunk_offset_next     = chunk_offset;
    max_buffer_bytes_next = cfg_write ? cfg_data : max_buffer_bytes;
    cmd                   = '0;
    cmd_push              = 1'b0;

    // zero buffer size behaves as one
    limit          = (max_buffer_bytes == '0) ? acdf_pkg::SIZE_W'(1) : max_buffer_bytes;
    magic_full     = {data_byte_in, preamble_magic[23:0]};
    frame_add      = header_flags[acdf_pkg::FLAG_STEREO_BIT] ?
                     FRAME_COUNT_WIDTH'(preamble_size) :
                     FRAME_COUNT_WIDTH'({preamble_size, 1'b0});
    left_dec       = chunk_left - acdf_pkg::SIZE_W'(1);
    fill_inc       = buffer_fill + acdf_pkg::SIZE_W'(1);
    pay_frame_last = (left_dec == '0);
    pay_buf_last   = pay_frame_last || (fill_inc >= limit);

    if (accept) begin
      unique case (phase)
        acdf_pkg::PH_HEADER: begin
          if (end_of_stream) begin
            phase_next = acdf_pkg::PH_DONE;
            cmd_push   = 1'b1;
            cmd        = finish_cmd(acdf_pkg::REASON_EOS);
          end else begin
            unique case (byte_idx)
              acdf_pkg::HDR_RATE_LO: header_rate_next = {8'h00, data_byte_in};
              acdf_pkg::HDR_RATE_HI: header_rate_next = {data_byte_in, header_rate[7:0]};
              acdf_pkg::HDR_FLAGS:   header_flags_next = data_byte_in[1:0];
              default: ;
            endcase
            if (byte_idx == acdf_pkg::HDR_CODEC) begin
              byte_idx_next = '0;
              if (header_rate < acdf_pkg::RATE_MIN || header_rate > acdf_pkg::RATE_MAX) begin
                phase_next = acdf_pkg::PH_DONE;
                cmd_push   = 1'b1;
                cmd        = finish_cmd(acdf_pkg::REASON_BAD_RATE);
              end else if (data_byte_in == acdf_pkg::CODEC_BYTE_PLAIN ||
                           data_byte_in == acdf_pkg::CODEC_BYTE_IMA) begin
                codec_next         = (data_byte_in == acdf_pkg::CODEC_BYTE_IMA);
                frame_total_next   = '0;
                data_position_next = '0;
                phase_next         = acdf_pkg::PH_PREAMBLE;
                cmd_push           = 1'b1;
                cmd.op             = acdf_pkg::CMD_HEADER;
                cmd.rate           = header_rate;
                cmd.stereo         = header_flags[acdf_pkg::FLAG_STEREO_BIT];
                cmd.sixteen        = header_flags[acdf_pkg::FLAG_WIDE_BIT];
                cmd.codec          = (data_byte_in == acdf_pkg::CODEC_BYTE_IMA);
              end else begin
                phase_next = acdf_pkg::PH_DONE;
                cmd_push   = 1'b1;
                cmd        = finish_cmd(acdf_pkg::REASON_BAD_CODEC);
              end
            end else begin
              byte_idx_next = byte_idx + acdf_pkg::IDX_W'(1);
            end
          end
        end

        acdf_pkg::PH_PREAMBLE: begin
          if (end_of_stream) begin
            phase_next = acdf_pkg::PH_DONE;
            cmd_push   = 1'b1;
            cmd        = finish_cmd(acdf_pkg::REASON_EOS);
          end else begin
            data_position_next = data_position + acdf_pkg::OFFSET_W'(1);
            unique case (byte_idx)
              acdf_pkg::PRE_SIZE_LO: begin
                preamble_size_next  = {8'h00, data_byte_in};
                preamble_magic_next = '0;
              end
              acdf_pkg::PRE_SIZE_HI: preamble_size_next = {data_byte_in, preamble_size[7:0]};
              acdf_pkg::PRE_MAGIC_0: preamble_magic_next[7:0]   = data_byte_in;
              acdf_pkg::PRE_MAGIC_1: preamble_magic_next[15:8]  = data_byte_in;
              acdf_pkg::PRE_MAGIC_2: preamble_magic_next[23:16] = data_byte_in;
              acdf_pkg::PRE_MAGIC_3: preamble_magic_next[31:24] = data_byte_in;
              default: ;
            endcase
            if (byte_idx == acdf_pkg::PRE_MAGIC_3) begin
              byte_idx_next = '0;
              if (magic_full != acdf_pkg::CHUNK_MAGIC) begin
                phase_next = acdf_pkg::PH_DONE;
                cmd_push   = 1'b1;
                cmd        = finish_cmd(acdf_pkg::REASON_BAD_MAGIC);
              end else begin
                frame_total_next  = frame_total + frame_add;
                chunk_left_next   = preamble_size;
                buffer_fill_next  = '0;
                chunk_offset_next = data_position + acdf_pkg::OFFSET_W'(1);
                // empty chunk: count moves on, nothing to stamp
                if (preamble_size != '0) begin
                  phase_next = acdf_pkg::PH_PAYLOAD;
                  cmd_push   = 1'b1;
                  cmd.op     = acdf_pkg::CMD_CHUNK;
                  cmd.rate   = header_rate;
                end
              end
            end else begin
              byte_idx_next = byte_idx + acdf_pkg::IDX_W'(1);
            end
          end
        end

        acdf_pkg::PH_PAYLOAD: begin
          if (end_of_stream) begin
            phase_next = acdf_pkg::PH_DONE;
            cmd_push   = 1'b1;
            cmd        = finish_cmd(acdf_pkg::REASON_TRUNCATED);
          end else begin
            chunk_left_next    = left_dec;
            buffer_fill_next   = pay_buf_last ? '0 : fill_inc;
            data_position_next = data_position + acdf_pkg::OFFSET_W'(1);
            if (pay_frame_last) begin
              phase_next = acdf_pkg::PH_PREAMBLE;
            end
            cmd_push     = 1'b1;
            cmd.op       = acdf_pkg::CMD_BYTE;
            cmd.data     = data_byte_in;
            cmd.buf_last = pay_buf_last;
            cmd.frm_last = pay_frame_last;
            cmd.offset   = chunk_offset;
          end
        end

        acdf_pkg::PH_DONE: ;

        default: phase_next = acdf_pkg::PH_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= acdf_pkg::PH_HEADER;
      byte_idx         <= '0;
      chunk_left       <= '0;
      buffer_fill      <= '0;
      frame_total      <= '0;
      data_position    <= '0;
      max_buffer_bytes <= acdf_pkg::MAX_BUFFER_RESET;
    end else begin
      phase            <= phase_next;
      byte_idx         <= byte_idx_next;
      chunk_left       <= chunk_left_next;
      buffer_fill      <= buffer_fill_next;
      frame_total      <= frame_total_next;
      data_position    <= data_position_next;
      max_buffer_bytes <= max_buffer_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    header_rate    <= header_rate_next;
    header_flags   <= header_flags_next;
    codec          <= codec_next;
    preamble_size  <= preamble_size_next;
    preamble_magic <= preamble_magic_next;
    chunk_offset   <= chunk_offset_next;
  end

  `ACDF_ASSERT_NEXT(a_fe_done_sticks, clk, rst, phase == acdf_pkg::PH_DONE, phase == acdf_pkg::PH_DONE && !cmd_push, "front end left finished state")

endmodule

// ----- design/acdf_back.sv -----
// Back end: stamp arithmetic per chunk and the result output register.
`timescale 1ns / 1ps
`include "audio_chunk_container_deframer_unit_assert.svh"
module acdf_back #(
  parameter int FRAME_COUNT_WIDTH = acdf_pkg::FRAME_COUNT_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  acdf_pkg::cmd_t               q_head,
  input  logic [FRAME_COUNT_WIDTH-1:0] q_head_frame,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output acdf_pkg::result_t            result
);

  localparam int PROD_W = FRAME_COUNT_WIDTH + acdf_pkg::SCALE_W;
  localparam int CNT_W  = $clog2(PROD_W + 1);
  localparam int SW     = acdf_pkg::STAMP_W;

  acdf_pkg::back_state_t       state, state_next;
  logic [CNT_W-1:0]            step_cnt;
  logic [acdf_pkg::SCALE_W-1:0] k_shift;
  logic [PROD_W-1:0]           work;
  logic [acdf_pkg::RATE_W-1:0] rem;
  logic [SW-1:0]               stamp_reg;
  logic [acdf_pkg::MS_W-1:0]   ms_reg;
  logic                        out_valid;
  acdf_pkg::result_t           out_reg;
  acdf_pkg::result_t           res_next;

  logic                        out_load;
  logic                        chunk_start;
  logic                        step_last;
  logic [PROD_W-1:0]           mul_sum;
  logic [acdf_pkg::RATE_W:0]   div_rem2;
  logic                        div_ge;
  logic [acdf_pkg::RATE_W:0]   div_rem_new;
  logic [PROD_W-1:0]           work_div;
  logic [acdf_pkg::MS_PART_W-1:0]  ms_part;
  logic [acdf_pkg::MS_PROD_W-1:0]  ms_prod;
  logic [acdf_pkg::MS_DIGIT_W-1:0] ms_q;
  logic [acdf_pkg::MS_PART_W-1:0]  ms_rem_full;
  logic [SW-1:0]               work_ms;

  assign empty  = !out_valid;
  assign result = out_reg;

  // frame * 90000, one multiplier bit per cycle, MSB first
  assign mul_sum = {work[PROD_W-2:0], 1'b0} +
                   (k_shift[acdf_pkg::SCALE_W-1] ? PROD_W'(q_head_frame) : '0);

  // restoring division of the product by the rate, quotient shifts in at the LSB
  assign div_rem2    = {rem, work[PROD_W-1]};
  assign div_ge      = (div_rem2 >= {1'b0, q_head.rate});
  assign div_rem_new = div_ge ? div_rem2 - {1'b0, q_head.rate} : div_rem2;
  assign work_div    = {work[PROD_W-2:0], div_ge};

  // stamp / 90, one 11-bit digit per cycle: reciprocal multiply gives the
  // digit quotient, the remainder carries into the next digit
  assign ms_part     = {rem[acdf_pkg::MS_REM_W-1:0],
                        work[SW-1 -: acdf_pkg::MS_DIGIT_W]};
  assign ms_prod     = acdf_pkg::MS_PROD_W'(ms_part) *
                       acdf_pkg::MS_PROD_W'(acdf_pkg::MS_RECIP);
  assign ms_q        = ms_prod[acdf_pkg::MS_RECIP_SHIFT +: acdf_pkg::MS_DIGIT_W];
  assign ms_rem_full = ms_part - acdf_pkg::MS_PART_W'(ms_q) *
                                 acdf_pkg::MS_PART_W'(acdf_pkg::MS_DIVISOR);
  assign work_ms     = {work[SW-acdf_pkg::MS_DIGIT_W-1:0], ms_q};

  always_comb begin
    state_next  = state;
    out_load    = 1'b0;
    chunk_start = 1'b0;
    step_last   = (step_cnt == CNT_W'(1));
    unique case (state)
      acdf_pkg::BK_SERVE: begin
        if (!q_empty) begin
          if (q_head.op == acdf_pkg::CMD_CHUNK) begin
            state_next  = acdf_pkg::BK_MUL;
            chunk_start = 1'b1;
          end else if (!out_valid || pop) begin
            out_load = 1'b1;
          end
        end
      end
      acdf_pkg::BK_MUL: if (step_last) state_next = acdf_pkg::BK_DIV;
      acdf_pkg::BK_DIV: if (step_last) state_next = acdf_pkg::BK_MS;
      acdf_pkg::BK_MS:  if (step_last) state_next = acdf_pkg::BK_SERVE;
      default: state_next = acdf_pkg::BK_SERVE;
    endcase
    // chunk request leaves the queue only once its stamp is final
    q_pop = out_load || (state == acdf_pkg::BK_MS && step_last);
  end

  always_comb begin
    res_next = '0;
    unique case (q_head.op)
      acdf_pkg::CMD_HEADER: begin
        res_next.kind           = acdf_pkg::KIND_HEADER;
        res_next.sample_rate    = q_head.rate;
        res_next.is_stereo      = q_head.stereo;
        res_next.is_sixteen_bit = q_head.sixteen;
        res_next.codec_kind     = q_head.codec;
      end
      acdf_pkg::CMD_BYTE: begin
        res_next.kind               = acdf_pkg::KIND_PAYLOAD;
        res_next.payload_byte       = q_head.data;
        res_next.buffer_last        = q_head.buf_last;
        res_next.frame_last         = q_head.frm_last;
        res_next.presentation_stamp = stamp_reg;
        res_next.time_ms            = ms_reg;
        res_next.chunk_offset       = q_head.offset;
      end
      acdf_pkg::CMD_FINISH: begin
        res_next.kind          = acdf_pkg::KIND_FINISHED;
        res_next.finish_reason = q_head.reason;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acdf_pkg::BK_SERVE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      acdf_pkg::BK_SERVE: begin
        if (chunk_start) begin
          work     <= '0;
          k_shift  <= acdf_pkg::STAMP_SCALE;
          step_cnt <= CNT_W'(acdf_pkg::SCALE_W);
        end
      end
      acdf_pkg::BK_MUL: begin
        work    <= mul_sum;
        k_shift <= {k_shift[acdf_pkg::SCALE_W-2:0], 1'b0};
        rem     <= '0;
        step_cnt <= step_last ? CNT_W'(PROD_W) : step_cnt - CNT_W'(1);
      end
      acdf_pkg::BK_DIV: begin
        if (step_last) begin
          stamp_reg <= work_div[SW-1:0];
          work      <= PROD_W'(work_div[SW-1:0]);
          rem       <= '0;
          step_cnt  <= CNT_W'(acdf_pkg::MS_STEPS);
        end else begin
          work     <= work_div;
          rem      <= div_rem_new[acdf_pkg::RATE_W-1:0];
          step_cnt <= step_cnt - CNT_W'(1);
        end
      end
      acdf_pkg::BK_MS: begin
        work     <= PROD_W'(work_ms);
        rem      <= acdf_pkg::RATE_W'(ms_rem_full[acdf_pkg::MS_REM_W-1:0]);
        step_cnt <= step_cnt - CNT_W'(1);
        if (step_last) begin
          ms_reg <= work_ms[acdf_pkg::MS_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= res_next;
    end
  end

  `ACDF_ASSERT_NOW(a_bk_busy_on_chunk, clk, rst, state != acdf_pkg::BK_SERVE,
                   !q_empty && q_head.op == acdf_pkg::CMD_CHUNK,
                   "stamp unit busy without a chunk request")
  `ACDF_ASSERT_NOW(a_bk_finish_is_last, clk, rst,
                   out_valid && out_reg.kind == acdf_pkg::KIND_FINISHED, q_empty,
                   "request queued after stream finished")

endmodule

// ----- design/audio_chunk_container_deframer_unit.sv -----
// Top level of the audio chunk container deframer.
`timescale 1ns / 1ps
// Byte-stream deframer for an audio chunk container. Bytes enter
// through a queue-style port (push/full), one per cycle while full is low; an
// item with end_of_stream set carries no byte. The 12-byte header yields one
// header result (rate, stereo, 16-bit, codec); each 8-byte chunk preamble
// (size, magic) is checked, and each payload byte comes out as one result with
// buffer_last/frame_last marks, the chunk offset and the chunk's 90 kHz stamp
// and millisecond time. Any bad field, or end of stream, yields one finished
// result with its reason, after which input is swallowed until reset.
// Results leave through a queue-style port (empty/pop) held in one output
// register; input keeps flowing while a result waits, until the queue fills.
// Rate: header, preamble and payload bytes are taken at one per cycle while
// full is low. Every chunk with a nonzero size first passes the back end
// through dispatch, shift-add multiply by 90000, restoring division by the
// rate and digit-wise reciprocal divide by 90 before its first payload byte
// is delivered; during that time the front end keeps parsing into a 4-entry
// request queue and raises full when it fills. Within a chunk, sustained
// payload throughput is one byte per cycle while results are popped.
// The max_buffer_bytes register is written through cfg_valid/cfg_ready/
// cfg_data (always ready) and should only change while the block is idle; a
// value of zero behaves as one.
module audio_chunk_container_deframer_unit #(
  parameter int FRAME_COUNT_WIDTH = acdf_pkg::FRAME_COUNT_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_in,
  input  logic        end_of_stream,
  // result output
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] sample_rate,
  output logic        is_stereo,
  output logic        is_sixteen_bit,
  output logic        codec_kind,
  output logic        buffer_last,
  output logic        frame_last,
  output logic [43:0] presentation_stamp,
  output logic [37:0] time_ms,
  output logic [31:0] chunk_offset,
  output logic [2:0]  finish_reason,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic                         accept;
  logic                         cmd_push;
  acdf_pkg::cmd_t               cmd;
  logic [FRAME_COUNT_WIDTH-1:0] cmd_frame;
  logic                         q_full;
  logic                         q_empty;
  logic                         q_pop;
  acdf_pkg::cmd_t               q_head;
  logic [FRAME_COUNT_WIDTH-1:0] q_head_frame;
  acdf_pkg::result_t            res;

  // every accepted byte may produce a request, so stall on a full queue
  assign full      = q_full;
  assign accept    = push && !q_full;
  assign cfg_ready = 1'b1;

  acdf_front #(
    .FRAME_COUNT_WIDTH(FRAME_COUNT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte_in  (data_byte_in),
    .end_of_stream (end_of_stream),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .cmd_push      (cmd_push),
    .cmd           (cmd),
    .cmd_frame     (cmd_frame)
  );

  acdf_cmd_queue #(
    .FRAME_COUNT_WIDTH(FRAME_COUNT_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .cmd_in     (cmd),
    .frame_in   (cmd_frame),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head),
    .head_frame (q_head_frame)
  );

  acdf_back #(
    .FRAME_COUNT_WIDTH(FRAME_COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_head_frame (q_head_frame),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .result       (res)
  );

  assign kind               = res.kind;
  assign payload_byte       = res.payload_byte;
  assign sample_rate        = res.sample_rate;
  assign is_stereo          = res.is_stereo;
  assign is_sixteen_bit     = res.is_sixteen_bit;
  assign codec_kind         = res.codec_kind;
  assign buffer_last        = res.buffer_last;
  assign frame_last         = res.frame_last;
  assign presentation_stamp = res.presentation_stamp;
  assign time_ms            = res.time_ms;
  assign chunk_offset       = res.chunk_offset;
  assign finish_reason      = res.finish_reason;

endmodule
